// ===== rtl/core/pkdt_pkg.sv =====
package pkdt_pkg;

    localparam int unsigned KEY_W    = 48;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned COUNT_W  = 5;

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_PRESENT   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        mode_t              mode;
        logic [KEY_W-1:0]   key_mac;
        logic [IDX_W-1:0]   entry_index;
    } req_t;

    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   result_index;
        status_t            status;
        logic [COUNT_W-1:0] count_after;
    } resp_t;

endpackage

// ===== rtl/core/pkdt_key_ram.sv =====
module pkdt_key_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [pkdt_pkg::KEY_W-1:0]   wr_data,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic [pkdt_pkg::KEY_W-1:0]   rd_data
);

    logic [pkdt_pkg::KEY_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/pkdt_ctrl.sv =====
module pkdt_ctrl #(
    parameter int unsigned MAX_ENTRIES = 16,
    parameter int unsigned AW          = 4,
    parameter int unsigned CW          = 5
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  pkdt_pkg::req_t               req,
    output logic                         res_valid,
    input  logic                         res_ready,
    output pkdt_pkg::resp_t              res,
    output logic                         wr_en,
    output logic [AW-1:0]                wr_addr,
    output logic [pkdt_pkg::KEY_W-1:0]   wr_data,
    output logic                         rd_en,
    output logic [AW-1:0]                rd_addr,
    input  logic [pkdt_pkg::KEY_W-1:0]   rd_data
);

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        SHIFT,
        RESP
    } state_t;

    state_t                        state_reg,  state_next;
    pkdt_pkg::mode_t               mode_reg,   mode_next;
    logic [pkdt_pkg::KEY_W-1:0]    key_reg,    key_next;
    logic [CW-1:0]                 ptr_reg,    ptr_next;
    logic [CW-1:0]                 count_reg,  count_next;
    logic [AW-1:0]                 rdidx_reg,  rdidx_next;
    logic                          pend_reg,   pend_next;
    logic                          found_reg,  found_next;
    logic [pkdt_pkg::IDX_W-1:0]    index_reg,  index_next;
    pkdt_pkg::status_t             status_reg, status_next;

    logic more;

    assign more      = ptr_reg < count_reg;
    assign in_ready  = state_reg == IDLE;
    assign res_valid = state_reg == RESP;
    assign rd_addr   = ptr_reg[AW-1:0];

    always_comb begin
        res.found        = found_reg;
        res.result_index = index_reg;
        res.status       = status_reg;
        res.count_after  = pkdt_pkg::COUNT_W'(count_reg);
    end

    always_comb begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        key_next    = key_reg;
        ptr_next    = ptr_reg;
        count_next  = count_reg;
        rdidx_next  = rdidx_reg;
        pend_next   = 1'b0;
        found_next  = found_reg;
        index_next  = index_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_addr     = AW'(rdidx_reg - 1'b1);
        wr_data     = rd_data;
        rd_en       = 1'b0;

        unique case (state_reg)
            IDLE: begin
                if (in_valid) begin
                    mode_next   = req.mode;
                    key_next    = req.key_mac;
                    found_next  = 1'b0;
                    index_next  = '0;
                    status_next = pkdt_pkg::ST_OK;
                    unique case (req.mode)
                        pkdt_pkg::MODE_LOOKUP, pkdt_pkg::MODE_ADD: begin
                            ptr_next   = '0;
                            state_next = SCAN;
                        end
                        pkdt_pkg::MODE_REMOVE: begin
                            if (32'(req.entry_index) >= 32'(count_reg)) begin
                                status_next = pkdt_pkg::ST_NOT_FOUND;
                                state_next  = RESP;
                            end else begin
                                ptr_next   = CW'(32'(req.entry_index) + 32'd1);
                                state_next = SHIFT;
                            end
                        end
                        pkdt_pkg::MODE_CLEAR: begin
                            count_next = '0;
                            state_next = RESP;
                        end
                        default: state_next = RESP;
                    endcase
                end
            end
            SCAN: begin
                if (pend_reg && rd_data == key_reg) begin
                    found_next  = 1'b1;
                    index_next  = pkdt_pkg::IDX_W'(rdidx_reg);
                    status_next = (mode_reg == pkdt_pkg::MODE_ADD) ?
                                  pkdt_pkg::ST_PRESENT : pkdt_pkg::ST_OK;
                    state_next  = RESP;
                end else if (more) begin
                    rd_en      = 1'b1;
                    rdidx_next = ptr_reg[AW-1:0];
                    pend_next  = 1'b1;
                    ptr_next   = ptr_reg + 1'b1;
                end else begin
                    state_next = RESP;
                    if (mode_reg != pkdt_pkg::MODE_ADD) begin
                        status_next = pkdt_pkg::ST_NOT_FOUND;
                    end else if (count_reg >= CW'(MAX_ENTRIES)) begin
                        status_next = pkdt_pkg::ST_FULL;
                    end else begin
                        wr_en      = 1'b1;
                        wr_addr    = count_reg[AW-1:0];
                        wr_data    = key_reg;
                        index_next = pkdt_pkg::IDX_W'(count_reg);
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            SHIFT: begin
                wr_en = pend_reg;
                if (more) begin
                    rd_en      = 1'b1;
                    rdidx_next = ptr_reg[AW-1:0];
                    pend_next  = 1'b1;
                    ptr_next   = ptr_reg + 1'b1;
                end else if (!pend_reg) begin
                    count_next = count_reg - 1'b1;
                    state_next = RESP;
                end
            end
            RESP: begin
                if (res_ready) begin
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
        mode_reg   <= mode_next;
        key_reg    <= key_next;
        ptr_reg    <= ptr_next;
        rdidx_reg  <= rdidx_next;
        found_reg  <= found_next;
        index_reg  <= index_next;
        status_reg <= status_next;
    end

endmodule

// ===== rtl/core/paired_device_key_table_core.sv =====
// Paired device key table.
// Input channel s_*: one transaction per request. s_tuser carries the mode
// (lookup, add, remove by index, clear); s_tdata carries the 48-bit key and
// the 4-bit entry index.
// Output channel m_*: exactly one transaction per request, in order, giving
// found, result index, status and the entry count after the request.
// Keys sit in a single-port-write, single-port-read RAM with a registered
// read port. Lookup and add stream through the stored entries one per
// cycle, stopping early on a hit. Remove copies each later entry down one
// place, one per cycle, through the single RAM read port. Clear and a
// rejected remove go straight to the response, without touching the RAM.
// One request is in flight at a time; s_tready is high only between
// requests. The result sits in an output register, so the next request
// may be taken while the previous result waits on m_tready; a stalled
// result holds the engine once it finishes the following request.
// Reset empties the table at once; stored keys need no clearing.
module paired_device_key_table_core #(
    parameter int unsigned MAX_ENTRIES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // key_mac[47:0], entry_index[51:48], zero pad
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // found[0], result_index[4:1], status[6:5],
                                   // count_after[11:7], zero pad
);

    localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

    pkdt_pkg::req_t              req;
    pkdt_pkg::resp_t             res;
    pkdt_pkg::resp_t             out_reg;
    logic                        out_valid_reg;
    logic                        res_valid;
    logic                        res_ready;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [pkdt_pkg::KEY_W-1:0]  wr_data;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [pkdt_pkg::KEY_W-1:0]  rd_data;

    always_comb begin
        req.mode        = pkdt_pkg::mode_t'(s_tuser);
        req.key_mac     = s_tdata[47:0];
        req.entry_index = s_tdata[51:48];
    end

    pkdt_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    pkdt_key_ram #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_reg.count_after, out_reg.status,
                       out_reg.result_index, out_reg.found};

endmodule

// ===== rtl/core/pkdt_checker.sv =====
module pkdt_checker #(
    parameter int unsigned MAX_ENTRIES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata
);

    logic       found;
    logic [1:0] status;
    logic [4:0] count;

    assign found  = m_tdata[0];
    assign status = m_tdata[6:5];
    assign count  = m_tdata[11:7];

    // one request in flight at a time
    a_single_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again straight after a transaction");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_found_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && found |->
            status == pkdt_pkg::ST_OK || status == pkdt_pkg::ST_PRESENT)
        else $error("found flag with failure status");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && status == pkdt_pkg::ST_FULL |-> count == 5'(MAX_ENTRIES))
        else $error("table full reported below capacity");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> MAX_ENTRIES > 31 || 32'(count) <= MAX_ENTRIES)
        else $error("entry count beyond capacity");

endmodule

bind paired_device_key_table_core pkdt_checker #(
    .MAX_ENTRIES (MAX_ENTRIES)
) u_pkdt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
